// File: rtl/tcw_pkg.sv
// Shared constants, command and status types for the text console writer.
// Depends on nothing; used by tcw_ctrl, tcw_dp and text_console_writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS + 1);

  // Port field widths
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 7;
  localparam int COLOR_W    = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;

  // Register indexes
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic REG_BACK_COLOR = 1'b1;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 4'd2;
  localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 4'd0;

  // Memory operations issued by the controller
  localparam logic [2:0] MEM_NONE  = 3'd0;
  localparam logic [2:0] MEM_INIT  = 3'd1;
  localparam logic [2:0] MEM_CLEAR = 3'd2;
  localparam logic [2:0] MEM_COPY  = 3'd3;
  localparam logic [2:0] MEM_FILL  = 3'd4;
  localparam logic [2:0] MEM_WRITE = 3'd5;
  localparam logic [2:0] MEM_READ  = 3'd6;

  typedef struct packed {
    logic [2:0] mem_op;
    logic       load;
    logic       row_inc;
    logic       row_clr;
    logic       col_clr;
    logic       col_inc;
    logic       resp;
  } tcw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ch_cr;
    logic            ch_lf;
    logic            ch_zero;
    logic            col_full;
    logic            row_last;
    logic            ptr_last;
    logic            copy_last;
    logic            out_busy;
  } tcw_sts_t;

endpackage

`default_nettype wire

// File: rtl/tcw_ctrl.sv
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_dp through tcw_cmd_t and reads tcw_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t     cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_WRITE  = 4'd3;
  localparam logic [3:0] S_COPY   = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_FILL   = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.mem_op = tcw_pkg::MEM_INIT;
        if (sts.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          tcw_pkg::OP_PUT: begin
            if (sts.ch_cr) begin
              cmd.col_clr = 1'b1;
              state_nxt   = S_RESP;
            end else if (sts.ch_lf) begin
              if (sts.row_last) begin
                state_nxt = S_COPY;
              end else begin
                cmd.row_inc = 1'b1;
                state_nxt   = S_RESP;
              end
            end else if (sts.ch_zero) begin
              state_nxt = S_RESP;
            end else if (sts.col_full) begin
              // lazy wrap: take the new line first
              cmd.col_clr = 1'b1;
              if (sts.row_last) begin
                state_nxt = S_COPY;
              end else begin
                cmd.row_inc = 1'b1;
                state_nxt   = S_WRITE;
              end
            end else begin
              state_nxt = S_WRITE;
            end
          end
          tcw_pkg::OP_CLEAR: state_nxt = S_CLEAR;
          tcw_pkg::OP_READ: begin
            cmd.mem_op = tcw_pkg::MEM_READ;
            state_nxt  = S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_WRITE: begin
        cmd.mem_op  = tcw_pkg::MEM_WRITE;
        cmd.col_inc = 1'b1;
        state_nxt   = S_RESP;
      end
      S_COPY: begin
        cmd.mem_op = tcw_pkg::MEM_COPY;
        if (sts.copy_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last copied row entry is written back this cycle
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.mem_op = tcw_pkg::MEM_FILL;
        if (sts.ptr_last) state_nxt = sts.ch_lf ? S_RESP : S_WRITE;
      end
      S_CLEAR: begin
        cmd.mem_op = tcw_pkg::MEM_CLEAR;
        if (sts.ptr_last) begin
          cmd.row_clr = 1'b1;
          cmd.col_clr = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tcw_dp.sv
// Datapath for the text console writer: screen memory, cursor, sweep pointer,
// latched request and result register. Depends on tcw_pkg; driven by tcw_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tcw_pkg::tcw_cmd_t                cmd,
  output tcw_pkg::tcw_sts_t                     sts,
  input  wire logic [tcw_pkg::COLOR_W-1:0]      text_color,
  input  wire logic [tcw_pkg::COLOR_W-1:0]      back_color,
  input  wire logic [tcw_pkg::OP_W-1:0]         in_operation,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       in_character,
  input  wire logic [tcw_pkg::IDX_W-1:0]        in_cell_index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]            out_cell_char,
  output logic [tcw_pkg::CHAR_W-1:0]            out_cell_attr,
  output logic [tcw_pkg::OUT_ROW_W-1:0]         out_cursor_row,
  output logic [tcw_pkg::OUT_COL_W-1:0]         out_cursor_col
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::CHAR_W;

  logic [2*CW-1:0] mem [tcw_pkg::CELLS];

  logic [AW-1:0]                 ptr_r, ptr_nxt;
  logic [tcw_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [tcw_pkg::OP_W-1:0]      op_r;
  logic [CW-1:0]                 ch_r;
  logic [tcw_pkg::IDX_W-1:0]     idx_r;
  logic                          rd_hit_r;
  logic                          cp_pend_r;
  logic [AW-1:0]                 cp_addr_r;
  logic [2*CW-1:0]               rdata_r;
  logic                          out_valid_r;
  logic [CW-1:0]                 out_char_r, out_attr_r;
  logic [tcw_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [tcw_pkg::OUT_COL_W-1:0] out_col_r;

  logic [AW-1:0]   cur_addr;
  logic [CW-1:0]   attr_text, attr_back;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [2*CW-1:0] wdata;
  logic            sweep;

  assign cur_addr  = AW'(AW'(row_r) * AW'(tcw_pkg::COLS)) + AW'(col_r);
  assign attr_text = {back_color, text_color};
  assign attr_back = {back_color, back_color};
  assign sweep     = (cmd.mem_op == tcw_pkg::MEM_INIT) || (cmd.mem_op == tcw_pkg::MEM_CLEAR) ||
                     (cmd.mem_op == tcw_pkg::MEM_COPY) || (cmd.mem_op == tcw_pkg::MEM_FILL);

  // Memory port selection; a pending copy write-back takes the write port.
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = '0;
    re    = 1'b0;
    raddr = AW'(ptr_r + AW'(tcw_pkg::COLS));
    if (cp_pend_r) begin
      we    = 1'b1;
      waddr = cp_addr_r;
      wdata = rdata_r;
    end else begin
      case (cmd.mem_op)
        tcw_pkg::MEM_INIT:  we = 1'b1;
        tcw_pkg::MEM_CLEAR: begin
          we    = 1'b1;
          wdata = {attr_back, tcw_pkg::CHAR_NUL};
        end
        tcw_pkg::MEM_FILL: begin
          we    = 1'b1;
          wdata = {attr_text, tcw_pkg::CHAR_NUL};
        end
        tcw_pkg::MEM_WRITE: begin
          we    = 1'b1;
          waddr = cur_addr;
          wdata = {attr_text, ch_r};
        end
        default: we = 1'b0;
      endcase
    end
    case (cmd.mem_op)
      tcw_pkg::MEM_COPY: re = 1'b1;
      tcw_pkg::MEM_READ: begin
        re    = rd_hit_r;
        raddr = AW'(idx_r);
      end
      default: re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Cursor and pointer update
  always_comb begin
    ptr_nxt = ptr_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.load) ptr_nxt = '0;
    else if (sweep) ptr_nxt = AW'(ptr_r + 1'b1);
    if (cmd.row_clr) row_nxt = '0;
    else if (cmd.row_inc) row_nxt = tcw_pkg::ROW_W'(row_r + 1'b1);
    if (cmd.col_clr) col_nxt = '0;
    else if (cmd.col_inc) col_nxt = tcw_pkg::COL_W'(col_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r     <= ptr_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      cp_pend_r <= (cmd.mem_op == tcw_pkg::MEM_COPY);
      if (cmd.resp) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_op == tcw_pkg::MEM_COPY) cp_addr_r <= ptr_r;
    if (cmd.load) begin
      op_r     <= in_operation;
      ch_r     <= in_character;
      idx_r    <= in_cell_index;
      rd_hit_r <= (in_operation == tcw_pkg::OP_READ) &&
                  (32'(in_cell_index) < 32'(tcw_pkg::CELLS));
    end
    if (cmd.resp) begin
      out_char_r <= rd_hit_r ? rdata_r[CW-1:0] : '0;
      out_attr_r <= rd_hit_r ? rdata_r[2*CW-1:CW] : '0;
      out_row_r  <= tcw_pkg::OUT_ROW_W'(row_r);
      out_col_r  <= tcw_pkg::OUT_COL_W'(col_r);
    end
  end

  assign sts.op        = op_r;
  assign sts.ch_cr     = (ch_r == tcw_pkg::CHAR_CR);
  assign sts.ch_lf     = (ch_r == tcw_pkg::CHAR_LF);
  assign sts.ch_zero   = (ch_r == tcw_pkg::CHAR_NUL);
  assign sts.col_full  = (col_r >= tcw_pkg::COL_W'(tcw_pkg::COLS));
  assign sts.row_last  = (row_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign sts.ptr_last  = (ptr_r == AW'(tcw_pkg::CELLS - 1));
  assign sts.copy_last = (ptr_r == AW'(tcw_pkg::CELLS - tcw_pkg::COLS - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// Text console writer: character-cell screen store with cursor and a register port
// for colors. An LF on the last row, or a character that wraps on the last row,
// scrolls the whole store first; clear sweeps every cell. One request in flight;
// the next is taken once the result is registered. After reset a clearing pass
// zeroes the whole screen memory first.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tcw_pkg::OP_W-1:0]            in_operation,
  input  wire logic [tcw_pkg::CHAR_W-1:0]          in_character,
  input  wire logic [tcw_pkg::IDX_W-1:0]           in_cell_index,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]               out_cell_char,
  output logic [tcw_pkg::CHAR_W-1:0]               out_cell_attr,
  output logic [tcw_pkg::OUT_ROW_W-1:0]            out_cursor_row,
  output logic [tcw_pkg::OUT_COL_W-1:0]            out_cursor_col,
  // register port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [tcw_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [tcw_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]           cfg_prdata,
  output logic                                     cfg_pready
);

  // Color registers: text color at byte address 0, back color at 4.
  logic [tcw_pkg::COLOR_W-1:0] text_color_r, back_color_r;
  logic                        cfg_wr;
  logic                        reg_sel;

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Write on the access phase; only the low nibble is kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::TEXT_COLOR_RST;
      back_color_r <= tcw_pkg::BACK_COLOR_RST;
    end else if (cfg_wr) begin
      if (reg_sel == tcw_pkg::REG_TEXT_COLOR) text_color_r <= cfg_pwdata[tcw_pkg::COLOR_W-1:0];
      else back_color_r <= cfg_pwdata[tcw_pkg::COLOR_W-1:0];
    end
  end

  // Read back the addressed register, zero-extended.
  assign cfg_prdata = (reg_sel == tcw_pkg::REG_TEXT_COLOR) ?
                      tcw_pkg::APB_DATA_W'(text_color_r) :
                      tcw_pkg::APB_DATA_W'(back_color_r);

  // Sequencer: decodes the held request and walks the memory for scroll,
  // clear and the power-up clearing pass.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Screen memory, cursor and result register.
  tcw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .text_color     (text_color_r),
    .back_color     (back_color_r),
    .in_operation   (in_operation),
    .in_character   (in_character),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for text_console_writer: random and directed console requests,
// with every result checked against a shadow copy of screen, cursor and colors.
// Depends on tcw_pkg and the text_console_writer RTL only.
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  // Operation code with no function: the block must leave everything alone
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Long receiver hold-off, in cycles, used to back the block up
  localparam int LONG_HOLD = 300;

  // What one result carries: the addressed cell and the cursor after the request
  typedef struct packed {
    logic [CHAR_W-1:0]    cell_char;
    logic [CHAR_W-1:0]    cell_attr;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
  } console_view_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_operation = '0;
  logic [CHAR_W-1:0]     in_character = '0;
  logic [IDX_W-1:0]      in_cell_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_W-1:0]     out_cell_char;
  logic [CHAR_W-1:0]     out_cell_attr;
  logic [OUT_ROW_W-1:0]  out_cursor_row;
  logic [OUT_COL_W-1:0]  out_cursor_col;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the screen store, the cursor and the color registers
  logic [CHAR_W-1:0]  shadow_char [CELLS];
  logic [CHAR_W-1:0]  shadow_attr [CELLS];
  int                 row_at;
  int                 col_at;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  // Views expected back from the block, oldest first
  console_view_t pending_views [$];

  int unsigned fail_count = 0;
  int unsigned requests_sent = 0;
  // Idle control for the sender and the receiver
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int unsigned holds_asked = 0;

  text_console_writer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_character   (in_character),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow console
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] current_attr();
    return {bg_color, fg_color};
  endfunction

  // Move down one row; on the last row shift the store up and blank the bottom
  // row in the current colors.
  function automatic void advance_line();
    if (row_at + 1 >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) begin
        shadow_char[i] = shadow_char[i + COLS];
        shadow_attr[i] = shadow_attr[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++) begin
        shadow_char[i] = '0;
        shadow_attr[i] = current_attr();
      end
      row_at = ROWS - 1;
    end else begin
      row_at++;
    end
  endfunction

  // Lazy wrap: a full row only turns into a new line when the next character lands.
  function automatic void place_char(input logic [CHAR_W-1:0] ch);
    if (col_at >= COLS) begin
      advance_line();
      col_at = 0;
    end
    shadow_char[row_at * COLS + col_at] = ch;
    shadow_attr[row_at * COLS + col_at] = current_attr();
    col_at++;
  endfunction

  // Apply one accepted request to the shadow and return the view it must produce.
  function automatic console_view_t predict_console_view(input logic [OP_W-1:0] op,
                                                         input logic [CHAR_W-1:0] ch,
                                                         input logic [IDX_W-1:0] idx);
    console_view_t view;
    view = '0;
    case (op)
      OP_PUT: begin
        if (ch == CHAR_CR) col_at = 0;
        else if (ch == CHAR_LF) advance_line();
        else if (ch != CHAR_NUL) place_char(ch);
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_char[i] = '0;
          shadow_attr[i] = {bg_color, bg_color};
        end
        row_at = 0;
        col_at = 0;
      end
      OP_READ: begin
        // Out-of-range cells read as zero
        if (idx < CELLS) begin
          view.cell_char = shadow_char[idx];
          view.cell_attr = shadow_attr[idx];
        end
      end
      default: ;
    endcase
    view.cursor_row = row_at[OUT_ROW_W-1:0];
    view.cursor_col = col_at[OUT_COL_W-1:0];
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CHAR_W-1:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CHAR_W'($urandom_range(32, 126));
    if (r < 95) return CHAR_W'($urandom_range(128, 255));
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  // Any byte and any cell index, for fields the request does not use.
  function automatic logic [CHAR_W-1:0] any_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, 2**IDX_W - 1));
  endfunction

  // Favor cells around the cursor, where the latest writes are; keep some
  // reads anywhere in the store and past its end.
  function automatic logic [IDX_W-1:0] pick_cell_index();
    int r;
    int cell_no;
    r = $urandom_range(0, 99);
    if (r < 45) cell_no = row_at * COLS + col_at - $urandom_range(0, 3);
    else if (r < 60) cell_no = (row_at - 1) * COLS + $urandom_range(0, COLS - 1);
    else if (r < 85) cell_no = $urandom_range(0, CELLS - 1);
    else if (r < 93) cell_no = $urandom_range(CELLS, 2**IDX_W - 1);
    else cell_no = $urandom_range(0, 2**IDX_W - 1);
    if (cell_no < 0) cell_no = 0;
    return cell_no[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until accepted, then record its expected view.
  // Valid stays high on return so a following request can go out back-to-back;
  // anything else that follows must drop valid first.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx);
    int gap;
    gap = tx_gaps_on ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_character  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_views.push_back(predict_console_view(op, ch, idx));
    requests_sent++;
  endtask

  // Drop valid and wait until every expected view has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_views.size() != 0);
  endtask

  // Write one color register over the register port, then read it back.
  // Random upper data bits must not reach the 4-bit register.
  task automatic write_color(input logic sel, input logic [COLOR_W-1:0] color);
    logic [APB_DATA_W-1:0] data;
    data = $urandom();
    data[COLOR_W-1:0] = color;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (sel == REG_TEXT_COLOR) fg_color = color;
    else bg_color = color;
    // Go straight into the read-back setup phase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== {{(APB_DATA_W-COLOR_W){1'b0}}, color}) begin
      $display("%0t: register %0d read-back mismatch, expected %0h, actual %0h",
               $time, sel, color, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Colors change only with the block idle.
  task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    drain_results();
    write_color(REG_TEXT_COLOR, fg);
    write_color(REG_BACK_COLOR, bg);
  endtask

  // One line of text: a run of characters with the odd read-back, then mostly a
  // line ending of some kind. Lengths cluster around a full row to hit the
  // lazy wrap and the line feed on a full row; the run never exceeds room.
  task automatic send_line(input int unsigned room);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 30) len = $urandom_range(0, 3);
    else if (r < 65) len = $urandom_range(4, 30);
    else if (r < 85) len = COLS - 1 + $urandom_range(0, 2);
    else len = $urandom_range(COLS + 1, 2 * COLS + 10);
    if (len > int'(room)) len = int'(room);
    for (int i = 0; i < len; i++) begin
      send_request(OP_PUT, text_byte(), any_index());
      if ($urandom_range(0, 15) == 0)
        send_request(OP_READ, any_byte(), pick_cell_index());
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_request(OP_PUT, CHAR_CR, any_index());
      send_request(OP_PUT, CHAR_LF, any_index());
    end else if (r < 80) begin
      send_request(OP_PUT, CHAR_LF, any_index());
    end else if (r < 90) begin
      send_request(OP_PUT, CHAR_CR, any_index());
    end
  endtask

  // Odd requests: the unused code, string terminators, stray controls, reads, clears.
  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_request(OP_UNUSED, any_byte(), any_index());
      1: send_request(OP_PUT, CHAR_NUL, any_index());
      2: send_request(OP_PUT, CHAR_CR, any_index());
      3: send_request(OP_READ, any_byte(), pick_cell_index());
      default: send_request(OP_CLEAR, any_byte(), any_index());
    endcase
  endtask

  // Mostly well-formed text with reads in between; a little noise.
  task automatic send_mixed(input int unsigned count);
    int unsigned stop_at;
    int r;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_line(stop_at - requests_sent);
      else if (r < 87) send_request(OP_READ, any_byte(), pick_cell_index());
      else send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh store reads as zero, at both ends and past the end.
  task automatic test_reset_contents();
    send_request(OP_READ, 8'h00, '0);
    send_request(OP_READ, 8'hFF, IDX_W'(CELLS - 1));
    send_request(OP_READ, 8'h00, IDX_W'(CELLS));
    send_request(OP_READ, 8'hFF, '1);
  endtask

  // Ordinary characters, terminator, carriage return, line feed, unused code.
  task automatic test_put_controls();
    send_request(OP_PUT, CHAR_NUL, '0);
    send_request(OP_PUT, 8'hFF, '1);
    send_request(OP_PUT, 8'h41, '0);
    send_request(OP_READ, 8'h00, IDX_W'(0));
    send_request(OP_READ, 8'h00, IDX_W'(1));
    send_request(OP_PUT, CHAR_CR, '0);
    send_request(OP_READ, 8'h00, IDX_W'(1));
    send_request(OP_PUT, CHAR_LF, '0);
    send_request(OP_PUT, 8'h01, '0);
    send_request(OP_READ, 8'h00, IDX_W'(COLS));
    send_request(OP_UNUSED, 8'hFF, '1);
  endtask

  // Clear fills with the background on both nibbles; new text takes both colors.
  task automatic test_clear_colors();
    write_colors(4'h0, 4'hF);
    send_request(OP_CLEAR, 8'h00, '0);
    send_request(OP_READ, 8'h00, IDX_W'(0));
    send_request(OP_READ, 8'h00, IDX_W'(CELLS - 1));
    send_request(OP_PUT, 8'h80, '0);
    send_request(OP_READ, 8'h00, IDX_W'(0));
  endtask

  task automatic test_text_stream();
    write_colors(TEXT_COLOR_RST, BACK_COLOR_RST);
    send_mixed(200);
  endtask

  // Exactly one row of text, then a line feed: the column stays full, so the
  // next character takes one more new line first.
  task automatic test_full_row_feed();
    send_request(OP_PUT, CHAR_CR, '0);
    for (int i = 0; i < COLS; i++) send_request(OP_PUT, text_byte(), '0);
    send_request(OP_PUT, CHAR_LF, '0);
    send_request(OP_READ, 8'h00, IDX_W'(row_at * COLS + COLS - 1));
    send_request(OP_PUT, text_byte(), '0);
    send_request(OP_READ, 8'h00, IDX_W'(row_at * COLS));
  endtask

  // Drive the cursor to the bottom row so that further lines scroll.
  task automatic test_scroll_region();
    for (int i = 0; i < ROWS + 5; i++) begin
      send_request(OP_PUT, CHAR_LF, any_index());
      if ($urandom_range(0, 3) == 0)
        send_request(OP_PUT, text_byte(), any_index());
    end
    send_mixed(100);
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so
  // the block backs up and stalls its input; then pause until it empties.
  task automatic test_output_backpressure();
    drain_results();
    holds_asked++;
    send_mixed(40);
    drain_results();
    send_mixed(20);
  endtask

  // Several color settings, the extremes first.
  task automatic test_color_phases();
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin fg = 4'h0; bg = 4'h0; end
        1: begin fg = 4'hF; bg = 4'hF; end
        2: begin fg = 4'hF; bg = 4'h0; end
        3: begin fg = 4'h0; bg = 4'hF; end
        default: begin
          fg = COLOR_W'($urandom_range(0, 15));
          bg = COLOR_W'($urandom_range(0, 15));
        end
      endcase
      write_colors(fg, bg);
      send_mixed(60);
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_no_idle();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_mixed(100);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    for (int i = 0; i < CELLS; i++) begin
      shadow_char[i] = '0;
      shadow_attr[i] = '0;
    end
    row_at   = 0;
    col_at   = 0;
    fg_color = TEXT_COLOR_RST;
    bg_color = BACK_COLOR_RST;

    // Hold reset a while; the block then runs its clearing pass with
    // in_ready low, which the handshake waits out.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_contents();
    test_put_controls();
    test_clear_colors();
    test_text_stream();
    test_full_row_feed();
    test_scroll_region();
    test_output_backpressure();
    test_color_phases();
    test_no_idle();

    // Let the last results come back, then watch a little longer for strays.
    drain_results();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver pacing: random gaps, plus a long hold-off whenever a test asks.
  initial begin : result_pacer
    int gap_left;
    int hold_left;
    int unsigned holds_granted;
    gap_left = 0;
    hold_left = 0;
    holds_granted = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        gap_left = rx_gaps_on ? idle_gap() : 0;
        if (gap_left > 0) begin
          gap_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every accepted result with the oldest expected view.
  initial begin : result_checker
    console_view_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        if (pending_views.size() == 0) begin
          $display("%0t: result with nothing expected, actual char %0h attr %0h row %0d col %0d",
                   $time, out_cell_char, out_cell_attr, out_cursor_row, out_cursor_col);
          fail_count++;
        end else begin
          want = pending_views.pop_front();
          check_field("cell_char", 32'(want.cell_char), 32'(out_cell_char));
          check_field("cell_attr", 32'(want.cell_attr), 32'(out_cell_attr));
          check_field("cursor_row", 32'(want.cursor_row), 32'(out_cursor_row));
          check_field("cursor_col", 32'(want.cursor_col), 32'(out_cursor_col));
        end
      end
    end
  end

  // Hard stop well past the slowest correct run: every request a full-store
  // scroll or clear behind the longest stalls, plus the clearing pass.
  initial begin : watchdog
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
